@@ rtl/core/rkd_pkg.sv @@
// ----------------------------------------------------------------------------
// rkd_pkg
// shared constants and command/status types for the key derivation core
// ----------------------------------------------------------------------------
package rkd_pkg;

    localparam int unsigned PRIME_WIDTH_DEF = 16;
    localparam logic [31:0] START_EXP       = 32'd65537;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_IN   = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;  // latch inputs, start product
    localparam logic [3:0] OP_MUL_STEP = 4'd2;  // one shift-add step of a product
    localparam logic [3:0] OP_GCD_INIT = 4'd3;  // x=p-1, y=q-1
    localparam logic [3:0] OP_DIV_INIT = 4'd4;  // start x / y restoring divide
    localparam logic [3:0] OP_DIV_STEP = 4'd5;  // one quotient bit
    localparam logic [3:0] OP_GCD_NEXT = 4'd6;  // x=y, y=rem
    localparam logic [3:0] OP_LCM_INIT = 4'd7;  // start (p-1)/g
    localparam logic [3:0] OP_TOT_INIT = 4'd8;  // start quotient*(q-1)
    localparam logic [3:0] OP_TOT_DONE = 4'd9;  // latch totient, e=start
    localparam logic [3:0] OP_EG_INIT  = 4'd10; // x=e, y=tot for gcd test
    localparam logic [3:0] OP_E_INC    = 4'd11; // e++
    localparam logic [3:0] OP_INV_INIT = 4'd12; // r0=tot, r1=e mod tot
    localparam logic [3:0] OP_INV_NEXT = 4'd13; // start qt*t1 mod m
    localparam logic [3:0] OP_MM_STEP  = 4'd14; // one step of mulmod
    localparam logic [3:0] OP_INV_UPD  = 4'd15; // t2, rotate

    typedef struct packed {
        logic [3:0] op;
        logic       set_ok;
        logic       set_bad;
        logic       set_ovf;
    } rkd_cmd_t;

    typedef struct packed {
        logic in_bad;     // p or q below two
        logic mul_done;   // shift-add product finished
        logic div_done;   // divider finished
        logic rem_zero;   // divider remainder zero
        logic y_zero;     // divisor register zero
        logic x_one;      // gcd result is one
        logic e_max;      // exponent at all ones
        logic tot_le1;    // totient <= 1
        logic r1_zero;    // euclid remainder zero
        logic mm_done;    // mulmod finished
    } rkd_stat_t;

endpackage

@@ rtl/core/rkd_datapath.sv @@
// ----------------------------------------------------------------------------
// rkd_datapath
// registers and iterative units: shift-add multiplier, restoring divider,
// shift-add modular multiplier, driven one step per command
// ----------------------------------------------------------------------------
module rkd_datapath #(
    parameter int unsigned PRIME_WIDTH = rkd_pkg::PRIME_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic [PRIME_WIDTH-1:0] prime_p,
    input  logic [PRIME_WIDTH-1:0] prime_q,
    input  rkd_pkg::rkd_cmd_t      cmd,
    output rkd_pkg::rkd_stat_t     stat,
    output logic [31:0]            modulus,
    output logic [31:0]            public_exponent,
    output logic [31:0]            private_exponent,
    output logic [1:0]             status
);
    import rkd_pkg::*;

    // totient holds up to 2*PRIME_WIDTH bits, exponent 32 bits
    localparam int unsigned TW  = 2 * PRIME_WIDTH;
    localparam int unsigned W   = (TW > 33) ? TW : 33;
    localparam int unsigned CW  = $clog2(W + 1);

    logic [PRIME_WIDTH-1:0] p_reg, q_reg;
    logic [W-1:0]  x_reg, y_reg, x_next, y_next;
    logic [W-1:0]  rem_reg, quo_reg, dvd_reg, rem_next, quo_next, dvd_next;
    logic [W-1:0]  tot_reg, tot_next;
    logic [W-1:0]  acc_reg, mcand_reg, mplier_reg, acc_next, mcand_next, mplier_next;
    logic [W-1:0]  t0_reg, t1_reg, t0_next, t1_next;
    logic [31:0]   e_reg, e_next;
    logic [31:0]   mod_reg, mod_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    st_reg, st_next;
    logic [31:0]   pub_reg, pub_next, prv_reg, prv_next;

    // divider step
    logic [W:0]   rem_sh;
    logic [W:0]   rem_sub;
    // mulmod addmod helpers
    logic [W:0]   acc_sum, a_dbl;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[W-1]};
        rem_sub = rem_sh - {1'b0, y_reg};
        acc_sum = {1'b0, acc_reg} + {1'b0, mcand_reg};
        if (acc_sum >= {1'b0, tot_reg}) begin
            acc_sum = acc_sum - {1'b0, tot_reg};
        end
        a_dbl = {1'b0, mcand_reg} + {1'b0, mcand_reg};
        if (a_dbl >= {1'b0, tot_reg}) begin
            a_dbl = a_dbl - {1'b0, tot_reg};
        end
    end

    // next-state datapath
    always_comb begin
        x_next = x_reg; y_next = y_reg;
        rem_next = rem_reg; quo_next = quo_reg; dvd_next = dvd_reg;
        tot_next = tot_reg; acc_next = acc_reg; mcand_next = mcand_reg;
        mplier_next = mplier_reg; t0_next = t0_reg; t1_next = t1_reg;
        e_next = e_reg; mod_next = mod_reg; cnt_next = cnt_reg;
        st_next = st_reg; pub_next = pub_reg; prv_next = prv_reg;
        case (cmd.op)
            OP_LOAD: begin
                acc_next    = '0;
                mcand_next  = W'(prime_p);
                mplier_next = W'(prime_q);
            end
            OP_MUL_STEP: begin
                if (mplier_reg[0]) acc_next = acc_reg + mcand_reg;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
            OP_GCD_INIT: begin
                mod_next = acc_reg[31:0];
                x_next   = W'(p_reg) - W'(1);
                y_next   = W'(q_reg) - W'(1);
            end
            OP_DIV_INIT: begin
                dvd_next = x_reg;
                rem_next = '0;
                quo_next = '0;
                cnt_next = CW'(W);
            end
            OP_DIV_STEP: begin
                if (!rem_sub[W]) begin
                    rem_next = rem_sub[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
            end
            OP_GCD_NEXT: begin
                x_next = y_reg;
                y_next = rem_reg;
            end
            OP_LCM_INIT: begin
                // x holds g; divide (p-1) by g
                y_next = x_reg;
                x_next = W'(p_reg) - W'(1);
            end
            OP_TOT_INIT: begin
                acc_next    = '0;
                mcand_next  = quo_reg;
                mplier_next = W'(q_reg) - W'(1);
            end
            OP_TOT_DONE: begin
                tot_next = acc_reg;
                e_next   = START_EXP;
            end
            OP_EG_INIT: begin
                x_next = W'(e_reg);
                y_next = tot_reg;
            end
            OP_E_INC: begin
                e_next = e_reg + 32'd1;
            end
            OP_INV_INIT: begin
                // r0 = tot in x, r1 = e mod tot comes from divider remainder
                x_next  = tot_reg;
                y_next  = rem_reg;
                t0_next = '0;
                t1_next = W'(1);
            end
            OP_INV_NEXT: begin
                // quotient of r0/r1 is ready; start qt*t1 mod tot
                acc_next    = '0;
                mcand_next  = quo_reg;
                mplier_next = t1_reg;
                if (quo_reg >= tot_reg) mcand_next = quo_reg - tot_reg;
            end
            OP_MM_STEP: begin
                if (mplier_reg[0]) acc_next = acc_sum[W-1:0];
                mcand_next  = a_dbl[W-1:0];
                mplier_next = mplier_reg >> 1;
            end
            OP_INV_UPD: begin
                x_next  = y_reg;
                y_next  = rem_reg;
                t0_next = t1_reg;
                t1_next = (t0_reg >= acc_reg) ? t0_reg - acc_reg
                                              : tot_reg - (acc_reg - t0_reg);
            end
            default: begin
            end
        endcase
        if (cmd.set_bad) begin
            mod_next = '0; pub_next = '0; prv_next = '0; st_next = STATUS_BAD_IN;
        end
        if (cmd.set_ovf) begin
            pub_next = '0; prv_next = '0; st_next = STATUS_OVERFLOW;
        end
        if (cmd.set_ok) begin
            pub_next = e_reg;
            prv_next = stat.tot_le1 ? 32'd0 : t0_reg[31:0];
            st_next  = STATUS_OK;
        end
    end

    // the quotient modmul for tot<=1 cannot happen; tot reduces mcand
    // divider input for e mod tot and r0/r1 reuses x/y via DIV_INIT
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            p_reg <= prime_p;
            q_reg <= prime_q;
        end
        x_reg <= x_next; y_reg <= y_next;
        rem_reg <= rem_next; quo_reg <= quo_next; dvd_reg <= dvd_next;
        tot_reg <= tot_next; acc_reg <= acc_next; mcand_reg <= mcand_next;
        mplier_reg <= mplier_next; t0_reg <= t0_next; t1_reg <= t1_next;
        e_reg <= e_next; mod_reg <= mod_next; cnt_reg <= cnt_next;
        st_reg <= st_next; pub_reg <= pub_next; prv_reg <= prv_next;
    end

    // status to controller
    always_comb begin
        stat.in_bad   = (prime_p < PRIME_WIDTH'(2)) || (prime_q < PRIME_WIDTH'(2));
        stat.mul_done = (mplier_reg == '0);
        stat.div_done = (cnt_reg == '0);
        stat.rem_zero = (rem_reg == '0);
        stat.y_zero   = (y_reg == '0);
        stat.x_one    = (x_reg == W'(1));
        stat.e_max    = (e_reg == 32'hFFFF_FFFF);
        stat.tot_le1  = (tot_reg <= W'(1));
        stat.r1_zero  = (y_reg == '0);
        stat.mm_done  = (mplier_reg == '0);
    end

    assign modulus          = mod_reg;
    assign public_exponent  = pub_reg;
    assign private_exponent = prv_reg;
    assign status           = st_reg;

endmodule

@@ rtl/core/rkd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rkd_ctrl
// sequencer for product, gcd/lcm, exponent search and extended euclid
// ----------------------------------------------------------------------------
module rkd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  rkd_pkg::rkd_stat_t stat,
    output rkd_pkg::rkd_cmd_t  cmd
);
    import rkd_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_MUL      = 5'd1;
    localparam logic [4:0] S_GCD_INIT = 5'd2;
    localparam logic [4:0] S_GCD_TEST = 5'd3;
    localparam logic [4:0] S_GCD_DIV  = 5'd4;
    localparam logic [4:0] S_GCD_NEXT = 5'd5;
    localparam logic [4:0] S_LCM_DIV  = 5'd6;
    localparam logic [4:0] S_TOT_MUL  = 5'd7;
    localparam logic [4:0] S_TOT_DONE = 5'd8;
    localparam logic [4:0] S_EG_INIT  = 5'd9;
    localparam logic [4:0] S_EG_TEST  = 5'd10;
    localparam logic [4:0] S_EG_DIV   = 5'd11;
    localparam logic [4:0] S_EG_NEXT  = 5'd12;
    localparam logic [4:0] S_EG_CHECK = 5'd13;
    localparam logic [4:0] S_INV_DIV  = 5'd14;
    localparam logic [4:0] S_INV_INIT = 5'd15;
    localparam logic [4:0] S_INV_TEST = 5'd16;
    localparam logic [4:0] S_INV_QDIV = 5'd17;
    localparam logic [4:0] S_INV_MM   = 5'd18;
    localparam logic [4:0] S_INV_UPD  = 5'd19;
    localparam logic [4:0] S_OUT      = 5'd20;
    localparam logic [4:0] S_LCM_INIT = 5'd21;
    localparam logic [4:0] S_INV_PRE  = 5'd22;

    logic [4:0] state_reg, state_next;
    logic       sub_reg, sub_next;  // first cycle of the lcm divide

    always_comb begin
        state_next = state_reg;
        sub_next   = 1'b0;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (stat.in_bad) begin
                        cmd.set_bad = 1'b1;
                        state_next  = S_OUT;
                    end else begin
                        cmd.op     = OP_LOAD;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (stat.mul_done) state_next = S_GCD_INIT;
                else cmd.op = OP_MUL_STEP;
            end
            S_GCD_INIT: begin
                cmd.op = OP_GCD_INIT; state_next = S_GCD_TEST;
            end
            S_GCD_TEST: begin
                if (stat.y_zero) state_next = S_LCM_INIT;
                else begin cmd.op = OP_DIV_INIT; state_next = S_GCD_DIV; end
            end
            S_GCD_DIV: begin
                if (stat.div_done) state_next = S_GCD_NEXT;
                else cmd.op = OP_DIV_STEP;
            end
            S_GCD_NEXT: begin
                cmd.op = OP_GCD_NEXT; state_next = S_GCD_TEST;
            end
            S_LCM_INIT: begin
                cmd.op = OP_LCM_INIT; sub_next = 1'b1; state_next = S_LCM_DIV;
            end
            S_LCM_DIV: begin
                if (sub_reg) cmd.op = OP_DIV_INIT;
                else if (stat.div_done) begin
                    cmd.op = OP_TOT_INIT; state_next = S_TOT_MUL;
                end else cmd.op = OP_DIV_STEP;
            end
            S_TOT_MUL: begin
                if (stat.mul_done) state_next = S_TOT_DONE;
                else cmd.op = OP_MUL_STEP;
            end
            S_TOT_DONE: begin
                cmd.op = OP_TOT_DONE; state_next = S_EG_INIT;
            end
            S_EG_INIT: begin
                cmd.op = OP_EG_INIT; state_next = S_EG_TEST;
            end
            S_EG_TEST: begin
                if (stat.y_zero) state_next = S_EG_CHECK;
                else begin cmd.op = OP_DIV_INIT; state_next = S_EG_DIV; end
            end
            S_EG_DIV: begin
                if (stat.div_done) state_next = S_EG_NEXT;
                else cmd.op = OP_DIV_STEP;
            end
            S_EG_NEXT: begin
                cmd.op = OP_GCD_NEXT; state_next = S_EG_TEST;
            end
            S_EG_CHECK: begin
                if (stat.x_one) begin
                    if (stat.tot_le1) begin
                        cmd.set_ok = 1'b1; state_next = S_OUT;
                    end else begin
                        // e mod tot: divide x=e by y=tot
                        cmd.op = OP_EG_INIT; state_next = S_INV_PRE;
                    end
                end else if (stat.e_max) begin
                    cmd.set_ovf = 1'b1; state_next = S_OUT;
                end else begin
                    cmd.op = OP_E_INC; state_next = S_EG_INIT;
                end
            end
            S_INV_PRE: begin
                cmd.op = OP_DIV_INIT; state_next = S_INV_DIV;
            end
            S_INV_DIV: begin
                if (stat.div_done) state_next = S_INV_INIT;
                else cmd.op = OP_DIV_STEP;
            end
            S_INV_INIT: begin
                cmd.op = OP_INV_INIT; state_next = S_INV_TEST;
            end
            S_INV_TEST: begin
                if (stat.r1_zero) begin
                    cmd.set_ok = 1'b1; state_next = S_OUT;
                end else begin
                    cmd.op = OP_DIV_INIT; state_next = S_INV_QDIV;
                end
            end
            S_INV_QDIV: begin
                if (stat.div_done) begin
                    cmd.op = OP_INV_NEXT; state_next = S_INV_MM;
                end else cmd.op = OP_DIV_STEP;
            end
            S_INV_MM: begin
                if (stat.mm_done) state_next = S_INV_UPD;
                else cmd.op = OP_MM_STEP;
            end
            S_INV_UPD: begin
                cmd.op = OP_INV_UPD; state_next = S_INV_TEST;
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sub_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
        end
    end

endmodule

@@ rtl/core/rsa_key_derivation.sv @@
// ----------------------------------------------------------------------------
// rsa_key_derivation
// derives modulus, public and private exponent from two primes
// ----------------------------------------------------------------------------
//  channel   ports                                       role
//  s_        s_valid s_ready s_prime_p s_prime_q        prime pair in
//  m_        m_valid m_ready m_modulus m_public_exponent
//            m_private_exponent m_status                key pair out
//
// one pair at a time; latency is data dependent, set by the one-bit-per-cycle
// restoring divider run once per euclid step in the gcd, lcm, exponent search
// and inverse loops
// reset returns the sequencer to idle; the result holds until transferred
// and a new pair is taken only after the result transfer
// ----------------------------------------------------------------------------
module rsa_key_derivation #(
    parameter int unsigned PRIME_WIDTH = rkd_pkg::PRIME_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PRIME_WIDTH-1:0] s_prime_p,
    input  logic [PRIME_WIDTH-1:0] s_prime_q,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_modulus,
    output logic [31:0]            m_public_exponent,
    output logic [31:0]            m_private_exponent,
    output logic [1:0]             m_status
);
    import rkd_pkg::*;

    rkd_cmd_t  cmd;
    rkd_stat_t stat;

    // sequencer
    rkd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic
    rkd_datapath #(.PRIME_WIDTH(PRIME_WIDTH)) u_dp (
        .aclk             (aclk),
        .prime_p          (s_prime_p),
        .prime_q          (s_prime_q),
        .cmd              (cmd),
        .stat             (stat),
        .modulus          (m_modulus),
        .public_exponent  (m_public_exponent),
        .private_exponent (m_private_exponent),
        .status           (m_status)
    );

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// key derivation check: prime pairs go in over a valid/ready channel, and
// each key pair that comes out is compared with a predicted modulus, public
// exponent, private exponent and status. Directed rows come first, then
// random pairs, with random idling on both sides, one long receiver hold-off
// and one sender pause that drains the block
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rkd_pkg::*;

    localparam int unsigned PW        = PRIME_WIDTH_DEF;
    localparam int          N_RANDOM  = 125;
    localparam longint      MAX_CYCLE = 64'd8_000_000;

    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] pub_exp;
        logic [31:0] priv_exp;
        logic [1:0]  status;
    } key_pair_t;

    typedef struct {
        logic [PW-1:0] p;
        logic [PW-1:0] q;
        bit            typed;
        key_pair_t     key;
    } pair_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [PW-1:0] s_prime_p = '0;
    logic [PW-1:0] s_prime_q = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [31:0]   m_modulus;
    logic [31:0]   m_public_exponent;
    logic [31:0]   m_private_exponent;
    logic [1:0]    m_status;

    key_pair_t pending_keys[$];
    int        mismatch_count = 0;
    longint    cycle_count = 0;
    int        recv_hold = 0;      // one-shot long hold-off request
    bit        no_idle = 1'b0;     // stretches with no idling

    rsa_key_derivation #(.PRIME_WIDTH(PW)) i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_prime_p          (s_prime_p),
        .s_prime_q          (s_prime_q),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_modulus          (m_modulus),
        .m_public_exponent  (m_public_exponent),
        .m_private_exponent (m_private_exponent),
        .m_status           (m_status)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // euclid on 64-bit values
    function automatic longint unsigned gcd_u64(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // key pair predicted from the two primes
    function automatic key_pair_t derive_key(logic [PW-1:0] p, logic [PW-1:0] q);
        key_pair_t       k;
        longint unsigned a, b, tot, e;
        longint          r0, r1, t0, t1, qt, tmp;
        k = '0;
        if (p < 2 || q < 2) begin
            k.status = STATUS_BAD_IN;
            return k;
        end
        k.modulus = 32'(longint'(p) * longint'(q));
        a = p - 1;
        b = q - 1;
        tot = (a / gcd_u64(a, b)) * b;
        e = START_EXP;
        while (gcd_u64(e, tot) != 1) begin
            if (e >= 64'hFFFF_FFFF) begin
                k.status = STATUS_OVERFLOW;
                return k;
            end
            e++;
        end
        k.pub_exp = 32'(e);
        k.status  = STATUS_OK;
        // extended euclid for e^-1 mod tot, zero when tot is one
        if (tot > 1) begin
            r0 = longint'(tot);
            r1 = longint'(e % tot);
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                qt = r0 / r1;
                tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
                tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
            end
            if (t0 < 0) t0 += longint'(tot);
            k.priv_exp = 32'(t0);
        end
        return k;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    // transfer monitor and checker
    always @(posedge aclk) begin
        key_pair_t k;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_keys.push_back(derive_key(s_prime_p, s_prime_q));
            if (m_valid && m_ready) begin
                if (pending_keys.size() == 0) begin
                    report_mismatch("unexpected key pair", m_modulus, 32'd0);
                end else begin
                    k = pending_keys.pop_front();
                    if (m_modulus !== k.modulus)
                        report_mismatch("modulus", m_modulus, k.modulus);
                    if (m_public_exponent !== k.pub_exp)
                        report_mismatch("public_exponent", m_public_exponent, k.pub_exp);
                    if (m_private_exponent !== k.priv_exp)
                        report_mismatch("private_exponent", m_private_exponent,
                                        k.priv_exp);
                    if (m_status !== k.status)
                        report_mismatch("status", 32'(m_status), 32'(k.status));
                end
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(10);
            if (recv_hold > 0) begin
                gap = recv_hold;
                recv_hold = 0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one prime pair transfer; valid stays high when the gap is zero
    task automatic send_pair(logic [PW-1:0] p, logic [PW-1:0] q);
        int gap;
        gap = no_idle ? 0 : $urandom_range(10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_prime_p <= p;
        s_prime_q <= q;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [PW-1:0] pick_prime();
        logic [PW-1:0] primes[] = '{2, 3, 5, 7, 11, 13, 17, 97, 257, 1021, 4099,
                                    32749, 65519, 65521, 65537 - 2};
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)  return PW'($urandom_range(1));
        if (sel < 55) return primes[$urandom_range(primes.size() - 1)];
        if (sel < 70) return PW'($urandom_range(300, 2));
        return PW'($urandom);
    endfunction

    initial begin
        pair_row_t rows[$];
        key_pair_t bad;
        bad = '{modulus: 0, pub_exp: 0, priv_exp: 0, status: STATUS_BAD_IN};
        rows = '{
            '{p: 0,     q: 0,     typed: 1, key: bad},
            '{p: 1,     q: 5,     typed: 1, key: bad},
            '{p: 5,     q: 1,     typed: 1, key: bad},
            '{p: 0,     q: 16'hFFFF, typed: 1, key: bad},
            '{p: 16'hFFFF, q: 1,  typed: 1, key: bad},
            '{p: 2,     q: 2,     typed: 1,
              key: '{modulus: 4, pub_exp: START_EXP, priv_exp: 0, status: STATUS_OK}},
            '{p: 2,     q: 3,     typed: 1,
              key: '{modulus: 6, pub_exp: START_EXP, priv_exp: 1, status: STATUS_OK}},
            '{p: 3,     q: 5,     typed: 0, key: '0},
            '{p: 61,    q: 53,    typed: 0, key: '0},
            '{p: 65521, q: 65519, typed: 0, key: '0},
            '{p: 16'hFFFF, q: 16'hFFFF, typed: 0, key: '0},
            '{p: 16'h8000, q: 16'h7FFF, typed: 0, key: '0},
            '{p: 16'hAAAA, q: 16'h5555, typed: 0, key: '0},
            '{p: 257,   q: 65537 - 2, typed: 0, key: '0},
            '{p: 3,     q: 3,     typed: 0, key: '0}
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; typed rows also check the predictor itself
        foreach (rows[i]) begin
            if (rows[i].typed && derive_key(rows[i].p, rows[i].q) !== rows[i].key) begin
                $display("table row %0d disagrees with prediction", i);
                mismatch_count++;
            end
            send_pair(rows[i].p, rows[i].q);
        end

        // random pairs with the pressure events folded in
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 10) recv_hold = 12000;
            no_idle = (n >= 40 && n < 55);
            if (n == 70) begin
                s_valid <= 1'b0;
                // let the monitor log the last transfer before draining
                @(posedge aclk);
                wait (pending_keys.size() == 0);
                @(posedge aclk);
            end
            send_pair(pick_prime(), pick_prime());
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (pending_keys.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
